// ===== rtl/vn3_pkg.sv =====
// Shared types and lattice hash constants for the 3D value noise block.
// No dependencies; imported by the hash stage and the top level.
`timescale 1ns / 1ps

package vn3_pkg;

  typedef logic [31:0] word_t;

  localparam word_t      Y_STEP    = 32'd257;
  localparam word_t      Z_STEP    = 32'd757;
  localparam int         XOR_SHIFT = 13;
  localparam word_t      HASH_MUL  = 32'd15731;
  localparam word_t      HASH_ADD1 = 32'd789221;
  localparam word_t      HASH_ADD2 = 32'd1376312589;
  localparam word_t      HASH_MASK = 32'h7fff_ffff;
  localparam int         HASH_BITS = 30;

endpackage

// ===== rtl/vn3_if.sv =====
// Valid/ready channel interfaces for the 3D value noise block: the
// coordinate request channel and the noise result channel. No dependencies.
`timescale 1ns / 1ps

interface vn3_req_if #(
  parameter int IN_W = 24
);
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] x_coord;
  logic signed [IN_W-1:0] y_coord;
  logic signed [IN_W-1:0] z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

interface vn3_res_if #(
  parameter int OUT_W = 18
);
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

// ===== rtl/vn3_hash.sv =====
// Five-stage lattice hash for the eight cell corners: xor-shift, square,
// scale and offset, final multiply, then mapping to a signed corner value.
// Depends on vn3_pkg.
`timescale 1ns / 1ps

module vn3_hash #(
  parameter int OUT_FRAC_BITS = 16,
  parameter int OUT_W         = 18
) (
  input  logic                    clk_i,
  input  logic [4:0]              ld_i,
  input  vn3_pkg::word_t          n0_i,
  output logic signed [OUT_W-1:0] cv_o [8]
);
  import vn3_pkg::*;

  localparam int SHR = HASH_BITS - OUT_FRAC_BITS;
  localparam logic [OUT_W-1:0] ONE = OUT_W'(1) << OUT_FRAC_BITS;

  for (genvar c = 0; c < 8; c++) begin : g_corner
    localparam word_t OFS = word_t'(c & 1) + word_t'((c >> 1) & 1) * Y_STEP
                          + word_t'((c >> 2) & 1) * Z_STEP;

    word_t            n_d, nx_d, u_d, v_d;
    logic [30:0]      h_d;
    logic [OUT_W-1:0] cv_d;
    word_t            nx_q, nxb_q, nxc_q, sq_q, u_q, v_q;
    logic [OUT_W-1:0] cv_q;

    always_comb begin
      n_d  = n0_i + OFS;
      nx_d = n_d ^ (n_d << XOR_SHIFT);
      u_d  = sq_q * HASH_MUL + HASH_ADD1;
      v_d  = nxc_q * u_q + HASH_ADD2;
      h_d  = 31'(v_q & HASH_MASK);
      cv_d = ONE - OUT_W'(h_d >> SHR);
    end

    always_ff @(posedge clk_i) begin
      if (ld_i[0]) begin
        nx_q <= nx_d;
      end
      if (ld_i[1]) begin
        sq_q  <= nx_q * nx_q;
        nxb_q <= nx_q;
      end
      if (ld_i[2]) begin
        u_q   <= u_d;
        nxc_q <= nxb_q;
      end
      if (ld_i[3]) begin
        v_q <= v_d;
      end
      if (ld_i[4]) begin
        cv_q <= cv_d;
      end
    end

    assign cv_o[c] = signed'(cv_q);
  end

endmodule

// ===== rtl/vn3_lerp.sv =====
// One registered linear blend stage over several lanes: a + floor((b-a)*f / 2^F).
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module vn3_lerp #(
  parameter int LANES     = 4,
  parameter int OUT_W     = 18,
  parameter int FRAC_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    ld_i,
  input  logic signed [OUT_W-1:0] a_i [LANES],
  input  logic signed [OUT_W-1:0] b_i [LANES],
  input  logic [FRAC_BITS-1:0]    f_i,
  output logic signed [OUT_W-1:0] r_o [LANES]
);

  localparam int PW = OUT_W + FRAC_BITS + 2;

  logic signed [OUT_W-1:0] r_d [LANES];
  logic signed [OUT_W-1:0] r_q [LANES];

  always_comb begin
    logic signed [OUT_W:0]     diff;
    logic signed [FRAC_BITS:0] fs;
    logic signed [PW-1:0]      prod;
    fs = signed'({1'b0, f_i});
    for (int i = 0; i < LANES; i++) begin
      diff   = (OUT_W + 1)'(b_i[i]) - (OUT_W + 1)'(a_i[i]);
      prod   = PW'(diff) * PW'(fs);
      r_d[i] = a_i[i] + OUT_W'(prod >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

// ===== rtl/value_noise_3d_trilinear.sv =====
// Top level of the 3D value noise block: lattice index stage, corner hash
// pipeline and three blend stages. Depends on vn3_pkg, vn3_if, vn3_hash, vn3_lerp.
//
// Usage:
//   req_i carries one coordinate triple (x_coord, y_coord, z_coord) in signed
//   fixed point per request; res_o returns one noise_value per request, in the
//   same order, in signed fixed point with OUT_FRAC_BITS fraction bits.
//   A z_coord of zero gives the 2D noise. Nothing is kept between requests.
//   From acceptance to res_o.valid a request passes one index stage, five
//   hash stages (set by the three chained 32-bit multiplies) and one blend stage
//   per axis. Throughput is one request per cycle while res_o is not stalled.
//   Each stage holds while the stage after it is full and stalled, so a stall
//   on res_o fills the empty stages first; req_i.ready falls only when all nine
//   stages hold a request. No request is lost or repeated.
//   Reset clears the stage valid bits; the pipeline is empty afterwards and no
//   clearing pass is needed.
`timescale 1ns / 1ps

module value_noise_3d_trilinear #(
  parameter int INT_BITS      = 12,
  parameter int FRAC_BITS     = 12,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vn3_req_if.sink   req_i,
  vn3_res_if.source res_o
);
  import vn3_pkg::*;

  localparam int IN_W  = INT_BITS + FRAC_BITS;
  localparam int OUT_W = OUT_FRAC_BITS + 2;
  localparam int S     = 9;
  localparam logic signed [OUT_W-1:0] NV_MAX = OUT_W'(1) << OUT_FRAC_BITS;
  localparam logic signed [OUT_W-1:0] NV_MIN = OUT_W'(1) - NV_MAX;

  typedef struct packed {
    logic [FRAC_BITS-1:0] xf;
    logic [FRAC_BITS-1:0] yf;
    logic [FRAC_BITS-1:0] zf;
  } frac_t;

  logic [S:1] vld_q, ld;
  word_t      n0_d, n0_q;
  frac_t      fr_d;
  frac_t      fr_q [1:S-1];

  logic signed [IN_W-1:0]  xs, ys, zs;
  logic signed [OUT_W-1:0] cv   [8];
  logic signed [OUT_W-1:0] xa   [4];
  logic signed [OUT_W-1:0] xb   [4];
  logic signed [OUT_W-1:0] xr   [4];
  logic signed [OUT_W-1:0] ya   [2];
  logic signed [OUT_W-1:0] yb   [2];
  logic signed [OUT_W-1:0] yr   [2];
  logic signed [OUT_W-1:0] za   [1];
  logic signed [OUT_W-1:0] zb   [1];
  logic signed [OUT_W-1:0] zr   [1];

  // advance a stage when it is empty or the next stage advances
  always_comb begin
    ld[S] = ~vld_q[S] | res_o.ready;
    for (int k = S - 1; k >= 1; k--) begin
      ld[k] = ~vld_q[k] | ld[k+1];
    end
  end

  assign req_i.ready = ld[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[1]) begin
        vld_q[1] <= req_i.valid;
      end
      for (int k = 2; k <= S; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // floor by arithmetic shift, fraction by mask
  always_comb begin
    xs      = req_i.x_coord >>> FRAC_BITS;
    ys      = req_i.y_coord >>> FRAC_BITS;
    zs      = req_i.z_coord >>> FRAC_BITS;
    n0_d    = word_t'(32'(xs)) + word_t'(32'(ys)) * Y_STEP + word_t'(32'(zs)) * Z_STEP;
    fr_d.xf = req_i.x_coord[FRAC_BITS-1:0];
    fr_d.yf = req_i.y_coord[FRAC_BITS-1:0];
    fr_d.zf = req_i.z_coord[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      n0_q     <= n0_d;
      fr_q[1]  <= fr_d;
    end
    for (int k = 2; k <= S - 1; k++) begin
      if (ld[k]) begin
        fr_q[k] <= fr_q[k-1];
      end
    end
  end

  vn3_hash #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS),
    .OUT_W         (OUT_W)
  ) u_hash (
    .clk_i (clk_i),
    .ld_i  (ld[6:2]),
    .n0_i  (n0_q),
    .cv_o  (cv)
  );

  for (genvar i = 0; i < 4; i++) begin : g_xpair
    assign xa[i] = cv[2*i];
    assign xb[i] = cv[2*i+1];
  end

  vn3_lerp #(
    .LANES     (4),
    .OUT_W     (OUT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp_x (
    .clk_i (clk_i),
    .ld_i  (ld[7]),
    .a_i   (xa),
    .b_i   (xb),
    .f_i   (fr_q[6].xf),
    .r_o   (xr)
  );

  for (genvar i = 0; i < 2; i++) begin : g_ypair
    assign ya[i] = xr[2*i];
    assign yb[i] = xr[2*i+1];
  end

  vn3_lerp #(
    .LANES     (2),
    .OUT_W     (OUT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp_y (
    .clk_i (clk_i),
    .ld_i  (ld[8]),
    .a_i   (ya),
    .b_i   (yb),
    .f_i   (fr_q[7].yf),
    .r_o   (yr)
  );

  assign za[0] = yr[0];
  assign zb[0] = yr[1];

  vn3_lerp #(
    .LANES     (1),
    .OUT_W     (OUT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp_z (
    .clk_i (clk_i),
    .ld_i  (ld[9]),
    .a_i   (za),
    .b_i   (zb),
    .f_i   (fr_q[8].zf),
    .r_o   (zr)
  );

  assign res_o.valid       = vld_q[S];
  assign res_o.noise_value = zr[0];

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (&vld_q))
    else $error("request blocked while a stage is empty");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> vld_q[1])
    else $error("accepted request did not enter the first stage");

  a_last_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[S-1] && ld[S]) |=> res_o.valid)
    else $error("request lost between last blend stages");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.noise_value >= NV_MIN) && (res_o.noise_value <= NV_MAX))
    else $error("noise value out of range");

endmodule

// ===== tb/value_noise_3d_trilinear_tb.sv =====
// Self-checking testbench for value_noise_3d_trilinear: drives coordinate requests with
// random gaps and result stalls, and predicts each noise value with an independent model.
// Depends on vn3_if.sv and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module value_noise_3d_trilinear_tb;

  localparam int IN_W      = 24;
  localparam int OUT_W     = 18;
  localparam int N_RANDOM  = 400;
  localparam int MAX_WAIT  = 12;
  localparam int LATENCY   = 9;
  localparam int CYCLE_CAP = 200000;

  typedef logic signed [IN_W-1:0]  coord_t;
  typedef logic signed [OUT_W-1:0] noise_t;

  class noise_scoreboard;
    localparam int FRAC      = 12;
    localparam int OUT_FRAC  = 16;
    localparam int VAL_SHIFT = 30 - OUT_FRAC;

    noise_t expected_q[$];
    int     mismatches;
    int     requests;
    int     results;

    function new();
      mismatches = 0;
      requests   = 0;
      results    = 0;
    endfunction

    function automatic int lattice_value(int xi, int yi, int zi);
      bit [31:0] n;
      bit [31:0] h;
      n = xi + 32'd257 * yi + 32'd757 * zi;
      n = n ^ (n << 13);
      h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
      return (1 << OUT_FRAC) - int'(h >> VAL_SHIFT);
    endfunction

    function automatic int blend_axis(int a, int b, int f);
      longint d;
      d = (longint'(b) - longint'(a)) * longint'(f);
      return a + int'(d >>> FRAC);
    endfunction

    function automatic noise_t predict_noise(coord_t x, coord_t y, coord_t z);
      int xi;
      int yi;
      int zi;
      int xf;
      int yf;
      int zf;
      int e00;
      int e01;
      int e10;
      int e11;
      int r;
      xi = int'(x) >>> FRAC;
      yi = int'(y) >>> FRAC;
      zi = int'(z) >>> FRAC;
      xf = int'(x[FRAC-1:0]);
      yf = int'(y[FRAC-1:0]);
      zf = int'(z[FRAC-1:0]);
      e00 = blend_axis(lattice_value(xi, yi, zi), lattice_value(xi + 1, yi, zi), xf);
      e01 = blend_axis(lattice_value(xi, yi + 1, zi), lattice_value(xi + 1, yi + 1, zi), xf);
      e10 = blend_axis(lattice_value(xi, yi, zi + 1), lattice_value(xi + 1, yi, zi + 1), xf);
      e11 = blend_axis(lattice_value(xi, yi + 1, zi + 1),
                       lattice_value(xi + 1, yi + 1, zi + 1), xf);
      r = blend_axis(blend_axis(e00, e01, yf), blend_axis(e10, e11, yf), zf);
      return noise_t'(r);
    endfunction

    function void note_request(coord_t x, coord_t y, coord_t z);
      expected_q.push_back(predict_noise(x, y, z));
      requests++;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(noise_t got);
      noise_t want;
      results++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("noise_value %0d with no request outstanding", got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("result %0d noise_value %0d, expected %0d",
                                    results, got, want));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycle_count = 0;
  bit   send_steady = 1'b0;
  bit   take_steady = 1'b0;
  int   n_directed;

  noise_scoreboard board;

  vn3_req_if #(.IN_W(IN_W))   req_if ();
  vn3_res_if #(.OUT_W(OUT_W)) res_if ();

  value_noise_3d_trilinear u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, board.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      board.check_result(res_if.noise_value);
  end

  // Hold a run of zero waits now and then, otherwise draw a random wait.
  function automatic int draw_wait(inout bit steady);
    if ($urandom_range(0, 19) == 0)
      steady = !steady;
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic send_coord(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    gap = draw_wait(send_steady);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.x_coord <= x;
    req_if.y_coord <= y;
    req_if.z_coord <= z;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(x, y, z);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0:       return coord_t'($urandom_range(0, 32767) - 16384);
      1:       return coord_t'($urandom() & 32'h00ff_f000);
      2:       return coord_t'($urandom_range(0, 8191) - 4096);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Sink side: stall for a random number of cycles, then take one result.
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_wait(take_steady);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  initial begin
    coord_t dir_x[$];
    coord_t dir_y[$];
    coord_t dir_z[$];
    coord_t z;
    board          = new();
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.x_coord <= '0;
    req_if.y_coord <= '0;
    req_if.z_coord <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // origin, 2D plane, extremes, exact negative integers, fraction edges, top corner
    dir_x = '{24'h000000, 24'h001800, 24'h7fffff, 24'h800000, 24'hfff000, 24'hffe000,
              24'h000fff, 24'h000001, 24'hffffff, 24'h7ff000, 24'h800fff, 24'h123456,
              24'hfedcba, 24'h7fffff, 24'h800000, 24'h000800, 24'hfff800, 24'h400000,
              24'h3fffff, 24'hc00000};
    dir_y = '{24'h000000, 24'h002400, 24'h7fffff, 24'h800000, 24'hfff000, 24'h000000,
              24'h000fff, 24'hffffff, 24'h000001, 24'h7ff000, 24'h800fff, 24'h654321,
              24'h0abcde, 24'h800000, 24'h7fffff, 24'hfff800, 24'h000800, 24'hc00000,
              24'hc00001, 24'h3fffff};
    dir_z = '{24'h000000, 24'h000000, 24'h7fffff, 24'h800000, 24'hfff000, 24'hff0000,
              24'h000fff, 24'h000000, 24'h000000, 24'h7ff000, 24'h800fff, 24'h000000,
              24'hf00fff, 24'h7fffff, 24'h800000, 24'h000800, 24'hfff800, 24'h000000,
              24'h7ff001, 24'h801000};
    foreach (dir_x[i])
      send_coord(dir_x[i], dir_y[i], dir_z[i]);
    n_directed = dir_x.size();
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2)
        drain_results();
      z = ($urandom_range(0, 7) == 0) ? coord_t'(0) : pick_coord();
      send_coord(pick_coord(), pick_coord(), z);
    end
    req_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);

    $display("Covered %0d coordinate requests (%0d directed), %0d noise results checked,",
             board.requests, n_directed, board.results);
    $display("with random request gaps and result stalls, %0d mismatches.", board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
